FILE: rtl/trc_pkg.sv
// Shared types and constants for the timed request controller.
package trc_pkg;

  localparam int TIME_W = 48;
  localparam int CNT16_W = 16;
  localparam int REQ_W = 32;
  localparam int SRC_W = 8;
  localparam int MAX_EV = 3;
  localparam int EVCNT_W = $clog2(MAX_EV + 1);

  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [CNT16_W-1:0] CNT16_MAX = '1;

  localparam logic [15:0] FRAME_BUDGET_RST = 16'd1;
  localparam logic [15:0] DEADLINE_MS_RST = 16'd1000;

  typedef enum logic {
    REG_FRAME_BUDGET = 1'b0,
    REG_DEADLINE_MS  = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    OP_POLL        = 3'd0,
    OP_REQUEST     = 3'd1,
    OP_FRAME       = 3'd2,
    OP_TICK        = 3'd3,
    OP_SET_ENABLE  = 3'd4,
    OP_END_SESSION = 3'd5,
    OP_PRIME       = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    RSN_ACCEPTED    = 3'd0,
    RSN_DUPLICATE   = 3'd1,
    RSN_NO_FRESH    = 3'd2,
    RSN_DEADLINE    = 3'd3,
    RSN_BUDGET      = 3'd4,
    RSN_DISABLED    = 3'd5,
    RSN_SESSION_END = 3'd6,
    RSN_SUPERSEDED  = 3'd7
  } reason_t;

  typedef enum logic {
    EV_STARTED  = 1'b0,
    EV_TERMINAL = 1'b1
  } ev_kind_t;

  typedef struct packed {
    logic [2:0]        op;
    logic [TIME_W-1:0] now_ms;
    logic              key_pressed;
    logic [SRC_W-1:0]  source_id;
    logic              fresh_frame;
    logic              offer_taken;
    logic              duplicate_content;
    logic              enable_value;
  } in_item_t;

  typedef struct packed {
    ev_kind_t           event_kind;
    reason_t            end_reason;
    logic [REQ_W-1:0]   request_number;
    logic [SRC_W-1:0]   event_source;
    logic [TIME_W-1:0]  event_time_ms;
    logic [CNT16_W-1:0] fresh_seen_count;
    logic [CNT16_W-1:0] stale_skipped_count;
    logic               last_event;
  } event_t;

  typedef struct packed {
    logic [EVCNT_W-1:0]       cnt;
    event_t [MAX_EV-1:0]      ev;
  } batch_t;

endpackage

FILE: rtl/trc_if.sv
// Valid/ready channel interfaces for input items and result events.
interface trc_in_if
  import trc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [2:0]        op;
  logic [TIME_W-1:0] now_ms;
  logic              key_pressed;
  logic [SRC_W-1:0]  source_id;
  logic              fresh_frame;
  logic              offer_taken;
  logic              duplicate_content;
  logic              enable_value;

  modport source (
    output valid, op, now_ms, key_pressed, source_id, fresh_frame,
           offer_taken, duplicate_content, enable_value,
    input  ready
  );
  modport sink (
    input  valid, op, now_ms, key_pressed, source_id, fresh_frame,
           offer_taken, duplicate_content, enable_value,
    output ready
  );
endinterface

interface trc_out_if
  import trc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               event_kind;
  logic [2:0]         end_reason;
  logic [REQ_W-1:0]   request_number;
  logic [SRC_W-1:0]   event_source;
  logic [TIME_W-1:0]  event_time_ms;
  logic [CNT16_W-1:0] fresh_seen_count;
  logic [CNT16_W-1:0] stale_skipped_count;
  logic               last_event;

  modport source (
    output valid, event_kind, end_reason, request_number, event_source,
           event_time_ms, fresh_seen_count, stale_skipped_count, last_event,
    input  ready
  );
  modport sink (
    input  valid, event_kind, end_reason, request_number, event_source,
           event_time_ms, fresh_seen_count, stale_skipped_count, last_event,
    output ready
  );
endinterface

FILE: rtl/trc_core.sv
// Request state, configuration registers and per-item event generation.
module trc_core
  import trc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [15:0] cfg_wdata,
  input  in_item_t    item,
  input  logic        take,
  output batch_t      batch
);

  logic [15:0]        budget_r, dl_ms_r;
  logic               en_r, key_r, act_r;
  logic [REQ_W-1:0]   reqn_r;
  logic [SRC_W-1:0]   src_r;
  logic [CNT16_W-1:0] flft_r, fresh_r, stale_r;
  logic [TIME_W-1:0]  dl_t_r;

  logic               en_nxt, key_nxt, act_nxt;
  logic [REQ_W-1:0]   reqn_nxt;
  logic [SRC_W-1:0]   src_nxt;
  logic [CNT16_W-1:0] flft_nxt, fresh_nxt, stale_nxt;
  logic [TIME_W-1:0]  dl_t_nxt;

  logic               dl_hit, chk, start;
  logic [TIME_W:0]    dl_sum;
  logic [TIME_W-1:0]  dl_new;
  logic [EVCNT_W-1:0] n;
  event_t [MAX_EV-1:0] evs;
  op_t                op;

  function automatic event_t mk_ev(ev_kind_t k, reason_t r, logic [REQ_W-1:0] q,
                                   logic [SRC_W-1:0] s, logic [TIME_W-1:0] t,
                                   logic [CNT16_W-1:0] f, logic [CNT16_W-1:0] st);
    event_t e;
    e.event_kind          = k;
    e.end_reason          = r;
    e.request_number      = q;
    e.event_source        = s;
    e.event_time_ms       = t;
    e.fresh_seen_count    = f;
    e.stale_skipped_count = st;
    e.last_event          = 1'b0;
    return e;
  endfunction

  assign op     = op_t'(item.op);
  assign dl_sum = {1'b0, item.now_ms} + {{(TIME_W - 15){1'b0}}, dl_ms_r};
  assign dl_new = dl_sum[TIME_W] ? TIME_MAX : dl_sum[TIME_W-1:0];
  assign dl_hit = act_r && (item.now_ms >= dl_t_r);

  always_comb begin
    en_nxt    = en_r;
    key_nxt   = key_r;
    act_nxt   = act_r;
    reqn_nxt  = reqn_r;
    src_nxt   = src_r;
    flft_nxt  = flft_r;
    fresh_nxt = fresh_r;
    stale_nxt = stale_r;
    dl_t_nxt  = dl_t_r;
    n         = '0;
    evs       = '0;
    chk       = 1'b0;
    start     = 1'b0;

    case (op)
      OP_POLL: begin
        chk     = 1'b1;
        start   = item.key_pressed & ~key_r;
        key_nxt = item.key_pressed;
      end
      OP_REQUEST: begin
        chk   = 1'b1;
        start = 1'b1;
      end
      OP_FRAME, OP_TICK: chk = 1'b1;
      OP_SET_ENABLE: en_nxt = item.enable_value;
      OP_PRIME: key_nxt = item.key_pressed;
      default: ;
    endcase

    if (chk && dl_hit) begin
      evs[n] = mk_ev(EV_TERMINAL, (fresh_r == '0) ? RSN_NO_FRESH : RSN_DEADLINE,
                     reqn_r, src_r, item.now_ms, fresh_r, stale_r);
      n = n + 1'b1;
      act_nxt = 1'b0;
    end

    if (start) begin
      if (act_nxt) begin
        evs[n] = mk_ev(EV_TERMINAL, RSN_SUPERSEDED, reqn_r, src_r, item.now_ms,
                       fresh_r, stale_r);
        n = n + 1'b1;
      end
      reqn_nxt  = reqn_r + 1'b1;
      src_nxt   = item.source_id;
      act_nxt   = 1'b1;
      flft_nxt  = budget_r;
      fresh_nxt = '0;
      stale_nxt = '0;
      dl_t_nxt  = dl_new;
      evs[n] = mk_ev(EV_STARTED, RSN_ACCEPTED, reqn_nxt, src_nxt, item.now_ms,
                     '0, '0);
      n = n + 1'b1;
      if (!en_r) begin
        evs[n] = mk_ev(EV_TERMINAL, RSN_DISABLED, reqn_nxt, src_nxt, item.now_ms,
                       '0, '0);
        n = n + 1'b1;
        act_nxt = 1'b0;
      end
    end

    if (op == OP_FRAME && act_nxt) begin
      if (!item.fresh_frame) begin
        if (stale_r != CNT16_MAX) stale_nxt = stale_r + 1'b1;
      end else begin
        if (fresh_r != CNT16_MAX) fresh_nxt = fresh_r + 1'b1;
        if (flft_r != '0) flft_nxt = flft_r - 1'b1;
        if (item.offer_taken || item.duplicate_content || flft_nxt == '0) begin
          evs[n] = mk_ev(EV_TERMINAL,
                         item.offer_taken ? RSN_ACCEPTED :
                         item.duplicate_content ? RSN_DUPLICATE : RSN_BUDGET,
                         reqn_r, src_r, item.now_ms, fresh_nxt, stale_r);
          n = n + 1'b1;
          act_nxt = 1'b0;
        end
      end
    end

    if ((op == OP_SET_ENABLE && !item.enable_value && act_r) ||
        (op == OP_END_SESSION && act_r)) begin
      evs[n] = mk_ev(EV_TERMINAL,
                     (op == OP_SET_ENABLE) ? RSN_DISABLED : RSN_SESSION_END,
                     reqn_r, src_r, item.now_ms, fresh_r, stale_r);
      n = n + 1'b1;
      act_nxt = 1'b0;
    end

    if (n != '0) evs[n - 1'b1].last_event = 1'b1;
  end

  assign batch.cnt = n;
  assign batch.ev  = evs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= FRAME_BUDGET_RST;
      dl_ms_r  <= DEADLINE_MS_RST;
      en_r     <= 1'b1;
      key_r    <= 1'b0;
      act_r    <= 1'b0;
      reqn_r   <= '0;
      src_r    <= '0;
      flft_r   <= '0;
      fresh_r  <= '0;
      stale_r  <= '0;
      dl_t_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_idx))
          REG_FRAME_BUDGET: budget_r <= (cfg_wdata == '0) ? 16'd1 : cfg_wdata;
          REG_DEADLINE_MS:  dl_ms_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (take) begin
        en_r    <= en_nxt;
        key_r   <= key_nxt;
        act_r   <= act_nxt;
        reqn_r  <= reqn_nxt;
        src_r   <= src_nxt;
        flft_r  <= flft_nxt;
        fresh_r <= fresh_nxt;
        stale_r <= stale_nxt;
        dl_t_r  <= dl_t_nxt;
      end
    end
  end

endmodule

FILE: rtl/trc_evq.sv
// Event queue: holds the events of one item and hands them out one per transfer.
module trc_evq
  import trc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             ld_vld,
  output logic             ld_rdy,
  input  batch_t           batch,
  trc_out_if.source        out_ch
);

  event_t [MAX_EV-1:0] q_r, q_nxt;
  logic [EVCNT_W-1:0]  cnt_r, cnt_nxt;
  logic                out_fire, ld_fire;

  assign out_fire = (cnt_r != '0) && out_ch.ready;
  assign ld_rdy   = (cnt_r == '0) || (cnt_r == EVCNT_W'(1) && out_ch.ready);
  assign ld_fire  = ld_vld && ld_rdy;

  always_comb begin
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    if (ld_fire) begin
      q_nxt   = batch.ev;
      cnt_nxt = batch.cnt;
    end else if (out_fire) begin
      for (int i = 0; i < MAX_EV - 1; i++) q_nxt[i] = q_r[i+1];
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign out_ch.valid               = (cnt_r != '0);
  assign out_ch.event_kind          = q_r[0].event_kind;
  assign out_ch.end_reason          = q_r[0].end_reason;
  assign out_ch.request_number      = q_r[0].request_number;
  assign out_ch.event_source        = q_r[0].event_source;
  assign out_ch.event_time_ms       = q_r[0].event_time_ms;
  assign out_ch.fresh_seen_count    = q_r[0].fresh_seen_count;
  assign out_ch.stale_skipped_count = q_r[0].stale_skipped_count;
  assign out_ch.last_event          = q_r[0].last_event;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= EVCNT_W'(MAX_EV))
    else $error("event queue count out of range");

  a_last_tail: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == EVCNT_W'(1) |-> q_r[0].last_event)
    else $error("final queued event not flagged last");

  a_last_only_tail: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r > EVCNT_W'(1) |-> !q_r[0].last_event)
    else $error("last flag ahead of remaining events");

  a_started_reason: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != '0 && q_r[0].event_kind == EV_STARTED |->
      q_r[0].end_reason == RSN_ACCEPTED && q_r[0].fresh_seen_count == '0)
    else $error("started event carries stale fields");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && cnt_r == EVCNT_W'(2) && !ld_vld |=> cnt_r == EVCNT_W'(1))
    else $error("queue did not drain by one on transfer");

endmodule

FILE: rtl/timed_request_controller_top.sv
// Top level of the timed request controller: input register, core and event queue.
// An accepted item is held in the input register and resolved there in the next
// cycle into zero to three events, which load into the event queue when it is ready
// and go out one per output transfer, the first after the input and queue registers.
// A new item is taken every cycle as long as the queue keeps up; an item with several
// events holds off the next until its last event goes out, and a stalled output holds
// the item in the input register and stops the input. Configuration writes (index 0
// frame budget, a zero stored as one; index 1 deadline in ms) are to be made by the
// user while the block is idle; the block itself does not enforce this.
module timed_request_controller_top
  import trc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [15:0] cfg_wdata,
  trc_in_if.sink      in_ch,
  trc_out_if.source   out_ch
);

  in_item_t item_r;
  logic     vld_r, vld_nxt;
  logic     ld_rdy, take, in_fire;
  batch_t   batch;

  assign in_ch.ready = ~vld_r | ld_rdy;
  assign in_fire     = in_ch.valid & in_ch.ready;
  assign take        = vld_r & ld_rdy;
  assign vld_nxt     = in_fire | (vld_r & ~ld_rdy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.op                <= in_ch.op;
      item_r.now_ms            <= in_ch.now_ms;
      item_r.key_pressed       <= in_ch.key_pressed;
      item_r.source_id         <= in_ch.source_id;
      item_r.fresh_frame       <= in_ch.fresh_frame;
      item_r.offer_taken       <= in_ch.offer_taken;
      item_r.duplicate_content <= in_ch.duplicate_content;
      item_r.enable_value      <= in_ch.enable_value;
    end
  end

  trc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .item      (item_r),
    .take      (take),
    .batch     (batch)
  );

  trc_evq u_evq (
    .clk    (clk),
    .rst_n  (rst_n),
    .ld_vld (vld_r),
    .ld_rdy (ld_rdy),
    .batch  (batch),
    .out_ch (out_ch)
  );

endmodule
